// File: hdl/erib_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// erib_pkg: shared types and codes for the edge range index builder
// Item and result beats, configuration view, opcodes, register indexes and
// controller states.
// ============================================================================
package erib_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        OP_OUT_EDGE = 2'd0,
        OP_IN_EDGE  = 2'd1,
        OP_LOOKUP   = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_CORE_NODE = 3'd0,
        REG_PATCH_NODES     = 3'd1,
        REG_CORE_NODES      = 3'd2,
        REG_PATCH_OUT_EDGES = 3'd3,
        REG_PATCH_IN_EDGES  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] node_id;
    } item_t;

    typedef struct packed {
        logic [15:0] out_start;
        logic [16:0] out_total;
        logic [15:0] in_start;
        logic [16:0] in_total;
    } result_t;

    typedef struct packed {
        logic [31:0] first_core_node;
        logic [6:0]  patch_nodes;
        logic [12:0] core_nodes;
        logic [16:0] patch_out_edges;
        logic [16:0] patch_in_edges;
    } cfg_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EDGE,
        S_CORE_SUB,
        S_CORE_CHK,
        S_SCAN,
        S_TBL_RD,
        S_TBL_WR,
        S_LOOK_RD,
        S_LOOK_OUT
    } state_t;

endpackage

// File: hdl/erib_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// erib_ram: simple dual-port synchronous memory
// One write port, one read port, read data registered.
// ============================================================================
module erib_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 33,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/erib_cfg_regs.sv
`timescale 1ns / 1ps
// ============================================================================
// erib_cfg_regs: configuration register file
// Decode the write index and hold the five setup registers.
// ============================================================================
module erib_cfg_regs
    import erib_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_FIRST_CORE_NODE: cfg_next.first_core_node = cfg_data;
                REG_PATCH_NODES:     cfg_next.patch_nodes     = cfg_data[6:0];
                REG_CORE_NODES:      cfg_next.core_nodes      = cfg_data[12:0];
                REG_PATCH_OUT_EDGES: cfg_next.patch_out_edges = cfg_data[16:0];
                REG_PATCH_IN_EDGES:  cfg_next.patch_in_edges  = cfg_data[16:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/edge_range_index_builder_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// edge_range_index_builder_unit: per-node edge range index
// Builds first-index / count tables from sorted edge streams, answers lookups.
// ============================================================================
// Usage
//   item channel (item_valid / item_stall / item): one beat per edge of the
//   out stream (OP_OUT_EDGE), the in stream (OP_IN_EDGE), or a lookup.
//   result channel (result_valid / result_stall / result): one beat per
//   lookup, carrying the out and in ranges of the node.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): setup
//   registers, always ready; write them only while the block is idle.
// Sequencing
//   One item is in work at a time; the block takes the next beat only once it
//   is back in S_IDLE. A core edge runs S_EDGE, S_CORE_SUB and S_CORE_CHK,
//   a patch edge S_EDGE and S_SCAN; both then do the table read-modify-write
//   in S_TBL_RD and S_TBL_WR. A core lookup runs S_CORE_SUB, S_CORE_CHK and
//   S_LOOK_RD and loads its result register in S_LOOK_OUT; a patch lookup
//   also passes S_SCAN, which reads the key map one slot per cycle through its
//   read port over the slots in use. Dropped edges finish earlier.
// Reset
//   After rst_n rises, a clearing sweep zeroes both tables, one entry per
//   cycle, through all MAX_NODES entries; item_stall stays high meanwhile.
// Backpressure
//   A held result keeps its register; the next item is still accepted and
//   runs up to the point where it needs the result register.
// ============================================================================
module edge_range_index_builder_unit
    import erib_pkg::*;
#(
    parameter int MAX_NODES       = 4096,
    parameter int MAX_PATCH_NODES = 64,
    parameter int MAX_EDGES       = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NODE_AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int PATCH_AW = (MAX_PATCH_NODES > 1) ? $clog2(MAX_PATCH_NODES) : 1;
    localparam int USED_W   = $clog2(MAX_PATCH_NODES + 1);
    localparam int POS_W    = $clog2(MAX_EDGES + 1);
    localparam int ENT_W    = POS_W + 16;   // {count, first}

    cfg_t cfg;

    // controller state
    state_t              state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [31:0]         node_reg, node_next;
    logic [NODE_AW-1:0]  clr_idx_reg, clr_idx_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;
    logic [POS_W-1:0]    in_pos_reg, in_pos_next;
    logic [31:0]         out_run_node_reg, out_run_node_next;
    logic                out_run_valid_reg, out_run_valid_next;
    logic [31:0]         in_run_node_reg, in_run_node_next;
    logic                in_run_valid_reg, in_run_valid_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic                fresh_reg, fresh_next;
    logic [POS_W-1:0]    p_reg, p_next;
    logic [NODE_AW-1:0]  slot_reg, slot_next;
    logic [USED_W-1:0]   scan_idx_reg, scan_idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [USED_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [31:0]         off_reg, off_next;
    logic                below_reg, below_next;
    logic                hit_reg, hit_next;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    // memory ports
    logic                out_we, in_we, tab_re;
    logic [NODE_AW-1:0]  tab_waddr;
    logic [ENT_W-1:0]    tab_wdata;
    logic [ENT_W-1:0]    out_rdata, in_rdata;
    logic                key_we, key_re;
    logic [PATCH_AW-1:0] key_waddr, key_raddr;
    logic [31:0]         key_rdata;

    // derived values
    logic                dir_in;
    logic [31:0]         lim32, scan_n32;
    logic [POS_W-1:0]    cur_pos;
    logic [31:0]         cur_patch_edges;
    logic [32:0]         core_sum;
    logic [ENT_W-1:0]    old_ent;
    logic [POS_W-1:0]    old_cnt, new_cnt;
    logic [15:0]         new_first;
    logic [31:0]         oc32, ic32;

    function automatic logic [15:0] p_reg_lo(input logic [POS_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    erib_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    erib_ram #(.DEPTH(MAX_NODES), .WIDTH(ENT_W), .AW(NODE_AW)) u_out_tab (
        .clk   (clk),
        .we    (out_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (slot_reg),
        .rdata (out_rdata)
    );

    erib_ram #(.DEPTH(MAX_NODES), .WIDTH(ENT_W), .AW(NODE_AW)) u_in_tab (
        .clk   (clk),
        .we    (in_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (slot_reg),
        .rdata (in_rdata)
    );

    erib_ram #(.DEPTH(MAX_PATCH_NODES), .WIDTH(32), .AW(PATCH_AW)) u_keys (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (node_reg),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // Slots in use are capped by the configured patch count and the map size.
    assign dir_in  = (op_reg == OP_IN_EDGE);
    assign lim32   = (32'(cfg.patch_nodes) < 32'(MAX_PATCH_NODES))
                     ? 32'(cfg.patch_nodes) : 32'(MAX_PATCH_NODES);
    assign scan_n32 = (32'(used_reg) < lim32) ? 32'(used_reg) : lim32;
    assign cur_pos = dir_in ? in_pos_reg : out_pos_reg;
    assign cur_patch_edges = dir_in ? 32'(cfg.patch_in_edges) : 32'(cfg.patch_out_edges);
    assign core_sum = {1'b0, off_reg} + 33'(cfg.patch_nodes);

    assign old_ent   = dir_in ? in_rdata : out_rdata;
    assign old_cnt   = old_ent[ENT_W-1:16];
    assign new_cnt   = (32'(old_cnt) < 32'(MAX_EDGES)) ? POS_W'(old_cnt + 1'b1) : old_cnt;
    assign new_first = fresh_reg ? p_reg_lo(p_reg) : old_ent[15:0];

    assign oc32 = 32'(out_rdata[ENT_W-1:16]);
    assign ic32 = 32'(in_rdata[ENT_W-1:16]);

    assign key_waddr = used_reg[PATCH_AW-1:0];
    assign key_raddr = scan_idx_reg[PATCH_AW-1:0];
    assign tab_waddr = (state_reg == S_CLEAR) ? clr_idx_reg : slot_reg;
    assign tab_wdata = (state_reg == S_CLEAR) ? '0 : {new_cnt, new_first};
    assign out_we    = (state_reg == S_CLEAR) || ((state_reg == S_TBL_WR) && !dir_in);
    assign in_we     = (state_reg == S_CLEAR) || ((state_reg == S_TBL_WR) && dir_in);

    always_comb
    begin
        state_next         = state_reg;
        op_next            = op_reg;
        node_next          = node_reg;
        clr_idx_next       = clr_idx_reg;
        out_pos_next       = out_pos_reg;
        in_pos_next        = in_pos_reg;
        out_run_node_next  = out_run_node_reg;
        out_run_valid_next = out_run_valid_reg;
        in_run_node_next   = in_run_node_reg;
        in_run_valid_next  = in_run_valid_reg;
        used_next          = used_reg;
        fresh_next         = fresh_reg;
        p_next             = p_reg;
        slot_next          = slot_reg;
        scan_idx_next      = scan_idx_reg;
        cmp_valid_next     = 1'b0;
        cmp_idx_next       = cmp_idx_reg;
        off_next           = off_reg;
        below_next         = below_reg;
        hit_next           = hit_reg;
        result_next        = result_reg;
        result_valid_next  = result_valid_reg && result_stall;
        tab_re             = 1'b0;
        key_re             = 1'b0;
        key_we             = 1'b0;
        item_stall         = 1'b1;

        case (state_reg)
            S_CLEAR:
            begin
                // sweep both tables to zero
                clr_idx_next = clr_idx_reg + 1'b1;
                if (32'(clr_idx_reg) == 32'(MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    op_next   = item.operation;
                    node_next = item.node_id;
                    case (op_t'(item.operation))
                        OP_OUT_EDGE: state_next = S_EDGE;
                        OP_IN_EDGE:  state_next = S_EDGE;
                        OP_LOOKUP:   state_next = S_CORE_SUB;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end

            S_EDGE:
            begin
                // run boundary, position advance, patch or core path
                fresh_next = (dir_in ? !in_run_valid_reg : !out_run_valid_reg)
                             || ((dir_in ? in_run_node_reg : out_run_node_reg) != node_reg)
                             || (32'(cur_pos) == cur_patch_edges);
                if (dir_in)
                begin
                    in_run_node_next  = node_reg;
                    in_run_valid_next = 1'b1;
                end
                else
                begin
                    out_run_node_next  = node_reg;
                    out_run_valid_next = 1'b1;
                end
                p_next = cur_pos;
                if (32'(cur_pos) >= 32'(MAX_EDGES))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    if (dir_in)
                    begin
                        in_pos_next = cur_pos + 1'b1;
                    end
                    else
                    begin
                        out_pos_next = cur_pos + 1'b1;
                    end
                    if (32'(cur_pos) < cur_patch_edges)
                    begin
                        scan_idx_next = '0;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_CORE_SUB;
                    end
                end
            end

            S_CORE_SUB:
            begin
                below_next = node_reg < cfg.first_core_node;
                off_next   = node_reg - cfg.first_core_node;
                state_next = S_CORE_CHK;
            end

            S_CORE_CHK:
            begin
                slot_next = core_sum[NODE_AW-1:0];
                if ((op_reg == OP_LOOKUP) && below_reg)
                begin
                    // node below the core range: search the patch map
                    scan_idx_next = '0;
                    state_next    = S_SCAN;
                end
                else if (!below_reg && (off_reg < 32'(cfg.core_nodes))
                         && (core_sum < 33'(MAX_NODES)))
                begin
                    hit_next   = 1'b1;
                    state_next = (op_reg == OP_LOOKUP) ? S_LOOK_RD : S_TBL_RD;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = (op_reg == OP_LOOKUP) ? S_LOOK_OUT : S_IDLE;
                end
            end

            S_SCAN:
            begin
                // issue one key read per cycle, compare the previous one
                if (cmp_valid_reg && (key_rdata == node_reg))
                begin
                    slot_next = NODE_AW'(cmp_idx_reg);
                    if (32'(cmp_idx_reg) < 32'(MAX_NODES))
                    begin
                        hit_next   = 1'b1;
                        state_next = (op_reg == OP_LOOKUP) ? S_LOOK_RD : S_TBL_RD;
                    end
                    else
                    begin
                        hit_next   = 1'b0;
                        state_next = (op_reg == OP_LOOKUP) ? S_LOOK_OUT : S_IDLE;
                    end
                end
                else if (32'(scan_idx_reg) < scan_n32)
                begin
                    key_re         = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg;
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end
                else if (op_reg == OP_LOOKUP)
                begin
                    hit_next   = 1'b0;
                    state_next = S_LOOK_OUT;
                end
                else if (fresh_reg && (32'(used_reg) < lim32))
                begin
                    // unseen patch node: give it the next dense slot
                    key_we    = 1'b1;
                    used_next = used_reg + 1'b1;
                    slot_next = NODE_AW'(used_reg);
                    state_next = (32'(used_reg) < 32'(MAX_NODES)) ? S_TBL_RD : S_IDLE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_TBL_RD:
            begin
                tab_re     = 1'b1;
                state_next = S_TBL_WR;
            end

            S_TBL_WR:
            begin
                state_next = S_IDLE;
            end

            S_LOOK_RD:
            begin
                tab_re     = 1'b1;
                state_next = S_LOOK_OUT;
            end

            S_LOOK_OUT:
            begin
                // hold until the result register is free
                if (!result_valid_reg || !result_stall)
                begin
                    if (hit_reg)
                    begin
                        result_next.out_total = oc32[16:0];
                        result_next.out_start = (oc32 != 32'd0) ? out_rdata[15:0] : 16'd0;
                        result_next.in_total  = ic32[16:0];
                        result_next.in_start  = (ic32 != 32'd0) ? in_rdata[15:0] : 16'd0;
                    end
                    else
                    begin
                        result_next = '0;
                    end
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_idx_reg       <= '0;
            out_pos_reg       <= '0;
            in_pos_reg        <= '0;
            out_run_node_reg  <= '0;
            out_run_valid_reg <= 1'b0;
            in_run_node_reg   <= '0;
            in_run_valid_reg  <= 1'b0;
            used_reg          <= '0;
            cmp_valid_reg     <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            clr_idx_reg       <= clr_idx_next;
            out_pos_reg       <= out_pos_next;
            in_pos_reg        <= in_pos_next;
            out_run_node_reg  <= out_run_node_next;
            out_run_valid_reg <= out_run_valid_next;
            in_run_node_reg   <= in_run_node_next;
            in_run_valid_reg  <= in_run_valid_next;
            used_reg          <= used_next;
            cmp_valid_reg     <= cmp_valid_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        node_reg     <= node_next;
        fresh_reg    <= fresh_next;
        p_reg        <= p_next;
        slot_reg     <= slot_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        off_reg      <= off_next;
        below_reg    <= below_next;
        hit_reg      <= hit_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // no item enters while the tables are being cleared
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> item_stall)
        else $error("item accepted during clearing sweep");

    // slot allocation never runs past the map
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= 32'(MAX_PATCH_NODES))
        else $error("patch slot count overflow");

    // the scan pointer never passes the map size
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (32'(scan_idx_reg) <= 32'(MAX_PATCH_NODES)))
        else $error("key scan beyond map");

    // a lookup that leaves its output state has loaded the result register
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_LOOK_OUT) && (!result_valid_reg || !result_stall))
        |=> result_valid_reg)
        else $error("lookup result lost");

    // table writes happen only in the sweep or the write-back step
    a_tab_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_we || in_we) |-> ((state_reg == S_CLEAR) || (state_reg == S_TBL_WR)))
        else $error("stray table write");

endmodule
